### design/igl_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and microcode for the integer ALU with gcd/lcm.
// No dependencies; imported by igl_seq, igl_dp and the top level.
package igl_pkg;

	localparam int OPERAND_WIDTH_DEF = 16;
	localparam int FIELD_W           = 16;
	localparam int KIND_W            = 3;
	localparam int RESULT_W          = 33;
	localparam int IN_TDATA_W        = 32;
	localparam int OUT_TDATA_W       = 40;
	localparam int UPC_W             = 5;

	typedef logic [UPC_W-1:0] upc_t;

	// operation kinds on s_axis_tuser
	localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
	localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
	localparam logic [KIND_W-1:0] KIND_REM = 3'd4;
	localparam logic [KIND_W-1:0] KIND_GCD = 3'd5;
	localparam logic [KIND_W-1:0] KIND_LCM = 3'd6;

	// microprogram labels
	localparam upc_t U_ADD      = 5'd0;
	localparam upc_t U_SUB      = 5'd1;
	localparam upc_t U_MUL      = 5'd2;
	localparam upc_t U_DIV      = 5'd3;
	localparam upc_t U_DIV_INIT = 5'd4;
	localparam upc_t U_DIV_LOOP = 5'd5;
	localparam upc_t U_DIV_OUT  = 5'd6;
	localparam upc_t U_REM      = 5'd7;
	localparam upc_t U_REM_INIT = 5'd8;
	localparam upc_t U_REM_LOOP = 5'd9;
	localparam upc_t U_REM_OUT  = 5'd10;
	localparam upc_t U_ERR      = 5'd11;
	localparam upc_t U_GCD      = 5'd12;
	localparam upc_t U_GCD_AZ   = 5'd13;
	localparam upc_t U_GCD_BZ   = 5'd14;
	localparam upc_t U_GCD_TWO  = 5'd15;
	localparam upc_t U_GCD_UEV  = 5'd16;
	localparam upc_t U_GCD_STEP = 5'd17;
	localparam upc_t U_GCD_OUT  = 5'd18;
	localparam upc_t U_GCD_B    = 5'd19;
	localparam upc_t U_GCD_A    = 5'd20;
	localparam upc_t U_LCM      = 5'd21;
	localparam upc_t U_LCM_AZ   = 5'd22;
	localparam upc_t U_LCM_BZ   = 5'd23;
	localparam upc_t U_LCM_TWO  = 5'd24;
	localparam upc_t U_LCM_UEV  = 5'd25;
	localparam upc_t U_LCM_STEP = 5'd26;
	localparam upc_t U_LCM_G    = 5'd27;
	localparam upc_t U_LCM_INIT = 5'd28;
	localparam upc_t U_LCM_LOOP = 5'd29;
	localparam upc_t U_LCM_OUT  = 5'd30;
	localparam upc_t U_ZERO     = 5'd31;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_RES_Q,
		OP_RES_R,
		OP_ERR,
		OP_GCD_TWO,
		OP_GCD_UEVEN,
		OP_GCD_STEP,
		OP_GCD_FIN,
		OP_RES_A,
		OP_RES_B
	} op_t;

	typedef enum logic [2:0] {
		CND_NONE,
		CND_A_ZERO,
		CND_B_ZERO,
		CND_AB_ZERO,
		CND_BOTH_EVEN,
		CND_U_EVEN,
		CND_V_NZ,
		CND_CNT_GT1
	} cnd_t;

	typedef struct packed {
		op_t  op;
		cnd_t cnd;
		upc_t tgt;
		logic fin;
	} ucode_t;

	typedef struct packed {
		logic a_zero;
		logic b_zero;
		logic both_even;
		logic u_even;
		logic v_nz;
		logic cnt_gt1;
	} flags_t;

	typedef struct packed {
		logic load;
		logic en;
		op_t  op;
	} ctl_t;

	function automatic ucode_t uw(input op_t op, input cnd_t cnd, input upc_t tgt,
			input logic fin);
		ucode_t w;
		w.op  = op;
		w.cnd = cnd;
		w.tgt = tgt;
		w.fin = fin;
		return w;
	endfunction

	// control store; a step jumps to tgt when its condition holds, else falls through
	function automatic ucode_t ucode_word(input upc_t addr);
		ucode_t w;
		w = uw(OP_NOP, CND_NONE, U_ZERO, 1'b1);
		case (addr)
			U_ADD:      w = uw(OP_ADD,       CND_NONE,      U_ZERO,     1'b1);
			U_SUB:      w = uw(OP_SUB,       CND_NONE,      U_ZERO,     1'b1);
			U_MUL:      w = uw(OP_MUL,       CND_NONE,      U_ZERO,     1'b1);
			U_DIV:      w = uw(OP_NOP,       CND_B_ZERO,    U_ERR,      1'b0);
			U_DIV_INIT: w = uw(OP_DIV_INIT,  CND_NONE,      U_ZERO,     1'b0);
			U_DIV_LOOP: w = uw(OP_DIV_STEP,  CND_CNT_GT1,   U_DIV_LOOP, 1'b0);
			U_DIV_OUT:  w = uw(OP_RES_Q,     CND_NONE,      U_ZERO,     1'b1);
			U_REM:      w = uw(OP_NOP,       CND_B_ZERO,    U_ERR,      1'b0);
			U_REM_INIT: w = uw(OP_DIV_INIT,  CND_NONE,      U_ZERO,     1'b0);
			U_REM_LOOP: w = uw(OP_DIV_STEP,  CND_CNT_GT1,   U_REM_LOOP, 1'b0);
			U_REM_OUT:  w = uw(OP_RES_R,     CND_NONE,      U_ZERO,     1'b1);
			U_ERR:      w = uw(OP_ERR,       CND_NONE,      U_ZERO,     1'b1);
			U_GCD:      w = uw(OP_NOP,       CND_AB_ZERO,   U_ERR,      1'b0);
			U_GCD_AZ:   w = uw(OP_NOP,       CND_A_ZERO,    U_GCD_B,    1'b0);
			U_GCD_BZ:   w = uw(OP_NOP,       CND_B_ZERO,    U_GCD_A,    1'b0);
			U_GCD_TWO:  w = uw(OP_GCD_TWO,   CND_BOTH_EVEN, U_GCD_TWO,  1'b0);
			U_GCD_UEV:  w = uw(OP_GCD_UEVEN, CND_U_EVEN,    U_GCD_UEV,  1'b0);
			U_GCD_STEP: w = uw(OP_GCD_STEP,  CND_V_NZ,      U_GCD_STEP, 1'b0);
			U_GCD_OUT:  w = uw(OP_GCD_FIN,   CND_NONE,      U_ZERO,     1'b1);
			U_GCD_B:    w = uw(OP_RES_B,     CND_NONE,      U_ZERO,     1'b1);
			U_GCD_A:    w = uw(OP_RES_A,     CND_NONE,      U_ZERO,     1'b1);
			U_LCM:      w = uw(OP_NOP,       CND_AB_ZERO,   U_ERR,      1'b0);
			U_LCM_AZ:   w = uw(OP_NOP,       CND_A_ZERO,    U_ZERO,     1'b0);
			U_LCM_BZ:   w = uw(OP_NOP,       CND_B_ZERO,    U_ZERO,     1'b0);
			U_LCM_TWO:  w = uw(OP_GCD_TWO,   CND_BOTH_EVEN, U_LCM_TWO,  1'b0);
			U_LCM_UEV:  w = uw(OP_GCD_UEVEN, CND_U_EVEN,    U_LCM_UEV,  1'b0);
			U_LCM_STEP: w = uw(OP_GCD_STEP,  CND_V_NZ,      U_LCM_STEP, 1'b0);
			U_LCM_G:    w = uw(OP_GCD_FIN,   CND_NONE,      U_ZERO,     1'b0);
			U_LCM_INIT: w = uw(OP_DIV_INIT,  CND_NONE,      U_ZERO,     1'b0);
			U_LCM_LOOP: w = uw(OP_DIV_STEP,  CND_CNT_GT1,   U_LCM_LOOP, 1'b0);
			U_LCM_OUT:  w = uw(OP_MUL,       CND_NONE,      U_ZERO,     1'b1);
			U_ZERO:     w = uw(OP_NOP,       CND_NONE,      U_ZERO,     1'b1);
			default:    w = uw(OP_NOP,       CND_NONE,      U_ZERO,     1'b1);
		endcase
		return w;
	endfunction

	function automatic upc_t dispatch(input logic [KIND_W-1:0] kind);
		upc_t a;
		unique case (kind)
			KIND_ADD: a = U_ADD;
			KIND_SUB: a = U_SUB;
			KIND_MUL: a = U_MUL;
			KIND_DIV: a = U_DIV;
			KIND_REM: a = U_REM;
			KIND_GCD: a = U_GCD;
			KIND_LCM: a = U_LCM;
			default:  a = U_ZERO;
		endcase
		return a;
	endfunction

endpackage

### design/igl_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on igl_pkg.
module igl_seq
	import igl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [KIND_W-1:0] kind,
	input  logic              out_stall,
	input  flags_t            flags,
	output logic              ready,
	output ctl_t              ctl,
	output logic              done
);

	typedef enum logic {S_IDLE, S_RUN} state_t;

	state_t state_q;
	upc_t   pc_q;
	ucode_t word;
	logic   jump;
	logic   hold;
	logic   accept;

	assign word   = ucode_word(pc_q);
	assign hold   = word.fin && out_stall;
	assign ready  = (state_q == S_IDLE);
	assign accept = in_valid && ready;
	assign done   = (state_q == S_RUN) && word.fin && !out_stall;

	assign ctl.load = accept;
	assign ctl.en   = (state_q == S_RUN) && !hold;
	assign ctl.op   = word.op;

	always_comb begin
		unique case (word.cnd)
			CND_NONE:      jump = 1'b0;
			CND_A_ZERO:    jump = flags.a_zero;
			CND_B_ZERO:    jump = flags.b_zero;
			CND_AB_ZERO:   jump = flags.a_zero && flags.b_zero;
			CND_BOTH_EVEN: jump = flags.both_even;
			CND_U_EVEN:    jump = flags.u_even;
			CND_V_NZ:      jump = flags.v_nz;
			CND_CNT_GT1:   jump = flags.cnt_gt1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= U_ZERO;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RUN;
						pc_q    <= dispatch(kind);
					end
				end
				S_RUN: begin
					// a final step waits here while the output register is full and not being taken
					if (!hold) begin
						if (word.fin)
							state_q <= S_IDLE;
						else if (jump)
							pc_q <= word.tgt;
						else
							pc_q <= pc_q + 1'b1;
					end
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && ready |=> !ready)
		else $error("sequencer ready right after a transaction");

	a_hold_final: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN && word.fin && out_stall |=> state_q == S_RUN && $stable(pc_q))
		else $error("final step left while output stalled");
`endif

endmodule

### design/igl_dp.sv
`timescale 1ns / 1ps
// Datapath: operand and work registers, shared subtract-shift unit, multiplier
// and result selection. Driven by control words from igl_seq. Depends on igl_pkg.
module igl_dp
	import igl_pkg::*;
#(
	parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctl_t                ctl,
	input  logic [FIELD_W-1:0]  operand_a,
	input  logic [FIELD_W-1:0]  operand_b,
	output flags_t              flags,
	output logic [RESULT_W-1:0] result,
	output logic                status
);

	localparam int W     = OPERAND_WIDTH;
	localparam int SW    = W + 2;
	localparam int CNT_W = $clog2(W + 1);
	localparam int K_W   = $clog2(W);

	logic [W-1:0]     a_q, b_q, u_q, v_q, r_q;
	logic [CNT_W-1:0] cnt_q;
	logic [K_W-1:0]   k_q;

	logic [W:0]       rs;
	logic [SW-1:0]    sub_x, sub_y, diff;
	logic             ge;
	logic [W-1:0]     g;
	logic [2*W-1:0]   prod;

	// partial remainder with the next dividend bit shifted in
	assign rs = {r_q, u_q[W-1]};

	always_comb begin
		if (ctl.op == OP_GCD_STEP) begin
			sub_x = SW'(v_q);
			sub_y = SW'(u_q);
		end else begin
			sub_x = SW'(rs);
			sub_y = SW'(v_q);
		end
	end

	assign diff = sub_x - sub_y;
	assign ge   = !diff[SW-1];
	assign g    = u_q << k_q;
	assign prod = u_q * b_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q <= W'(operand_a);
			b_q <= W'(operand_b);
			u_q <= W'(operand_a);
			v_q <= W'(operand_b);
			k_q <= '0;
		end else if (ctl.en) begin
			unique case (ctl.op)
				OP_DIV_INIT: begin
					u_q   <= a_q;
					r_q   <= '0;
					cnt_q <= CNT_W'(W);
				end
				OP_DIV_STEP: begin
					r_q   <= ge ? diff[W-1:0] : rs[W-1:0];
					u_q   <= {u_q[W-2:0], ge};
					cnt_q <= cnt_q - 1'b1;
				end
				OP_GCD_TWO: begin
					if (!u_q[0] && !v_q[0]) begin
						u_q <= u_q >> 1;
						v_q <= v_q >> 1;
						k_q <= k_q + 1'b1;
					end
				end
				OP_GCD_UEVEN: begin
					if (!u_q[0])
						u_q <= u_q >> 1;
				end
				OP_GCD_STEP: begin
					// u stays odd; v is halved, reduced by u, or swapped with u
					if (v_q != '0) begin
						if (!v_q[0]) begin
							v_q <= v_q >> 1;
						end else if (ge) begin
							v_q <= diff[W-1:0];
						end else begin
							u_q <= v_q;
							v_q <= u_q;
						end
					end
				end
				OP_GCD_FIN: v_q <= g;
				default: ;
			endcase
		end
	end

	assign flags.a_zero    = (a_q == '0);
	assign flags.b_zero    = (b_q == '0);
	assign flags.both_even = !u_q[0] && !v_q[0];
	assign flags.u_even    = !u_q[0];
	assign flags.v_nz      = (v_q != '0);
	assign flags.cnt_gt1   = (cnt_q != CNT_W'(1));

	always_comb begin
		result = '0;
		status = 1'b0;
		unique case (ctl.op)
			OP_ADD:     result = RESULT_W'(a_q) + RESULT_W'(b_q);
			OP_SUB:     result = RESULT_W'(a_q) - RESULT_W'(b_q);
			OP_MUL:     result = RESULT_W'(prod);
			OP_RES_Q:   result = RESULT_W'(u_q);
			OP_RES_R:   result = RESULT_W'(r_q);
			OP_GCD_FIN: result = RESULT_W'(g);
			OP_RES_A:   result = RESULT_W'(a_q);
			OP_RES_B:   result = RESULT_W'(b_q);
			OP_ERR:     status = 1'b1;
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.en && ctl.op == OP_DIV_STEP |-> cnt_q != '0)
		else $error("divide step with exhausted bit count");

	a_gcd_u_odd: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.en && ctl.op == OP_GCD_STEP && v_q != '0 |-> u_q[0])
		else $error("gcd reduction with even u");
`endif

endmodule

### design/integer_alu_gcd_lcm_top.sv
`timescale 1ns / 1ps
// Integer ALU with gcd and lcm: input handshake, microcoded core and output register.
// Depends on igl_pkg, igl_seq and igl_dp.
//
// Usage:
//   Input stream: s_axis_tuser carries the operation kind (0 add, 1 subtract,
//   2 multiply, 3 divide, 4 remainder, 5 gcd, 6 lcm, 7 gives 0); s_axis_tdata
//   carries operand_a in [15:0] and operand_b in [31:16].
//   Output stream: one transaction per input, m_axis_tdata[32:0] is the result
//   (two's complement), m_axis_tuser is the status (1 on zero divisor or gcd/lcm
//   of two zeros, with result 0).
//   Core steps (one per cycle from the control store, unless the core holds):
//     add, subtract, multiply, kind 7: the result step
//     zero divisor, gcd/lcm of two zeros: a zero check, then the error step
//     divide, remainder: init, a loop with one quotient bit per step, then the result
//     gcd: data-dependent loops; with one zero, the other operand is the result
//     lcm: gcd steps, then divide a by the gcd, then multiply by b
//   The core takes a new item in the cycle after it finishes the previous one; the result
//   shows on m_axis_tvalid in the cycle after the last step.
//   A finished result waits in the output register while the next item runs; if it is
//   still full and m_axis_tready is low at the next final step, the core holds.
//   Reset empties the output register and returns the core to idle.
module integer_alu_gcd_lcm_top
	import igl_pkg::*;
#(
	parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // operand_a, operand_b
	input  logic [KIND_W-1:0]      s_axis_tuser,  // kind
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // result, zero pad
	output logic [0:0]             m_axis_tuser   // status
);

	flags_t              flags;
	ctl_t                ctl;
	logic                done;
	logic                out_stall;
	logic [RESULT_W-1:0] result;
	logic                status;

	logic                m_valid_q;
	logic [RESULT_W-1:0] m_result_q;
	logic                m_status_q;

	assign out_stall = m_valid_q && !m_axis_tready;

	igl_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.kind      (s_axis_tuser),
		.out_stall (out_stall),
		.flags     (flags),
		.ready     (s_axis_tready),
		.ctl       (ctl),
		.done      (done)
	);

	igl_dp #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.operand_a (s_axis_tdata[FIELD_W-1:0]),
		.operand_b (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
		.flags     (flags),
		.result    (result),
		.status    (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (done)
			m_valid_q <= 1'b1;
		else if (m_axis_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (done) begin
			m_result_q <= result;
			m_status_q <= status;
		end
	end

	assign m_axis_tvalid   = m_valid_q;
	assign m_axis_tdata    = OUT_TDATA_W'(m_result_q);
	assign m_axis_tuser[0] = m_status_q;

endmodule
